@@ design/cen_pkg.sv @@
`default_nettype none
package cen_pkg;

  localparam int unsigned MAX_NEURONS_DEF = 16;

  // fixed number formats
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned DT_W   = 17;
  localparam int unsigned ACT_W  = 5;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MPROD_W = 52;  // (y - s) * dt, signed
  localparam int unsigned DIV_W   = 50;  // magnitude of that product

  localparam logic [DT_W-1:0]  DT_RESET  = 17'd655;
  localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

  localparam logic [32:0] ONE_Q   = 33'd65536;
  localparam logic [32:0] SIG_SAT = 33'd327680;  // 5.0
  localparam logic [32:0] SIG_MID = 33'd155648;  // 2.375
  localparam logic [32:0] SIG_OFF_HI  = 33'd55296;
  localparam logic [32:0] SIG_OFF_MID = 33'd40960;
  localparam logic [32:0] SIG_OFF_LO  = 33'd32768;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [CMD_W-1:0] {
    CMD_WEIGHT  = 3'd0,
    CMD_BIAS    = 3'd1,
    CMD_TAU     = 3'd2,
    CMD_GAIN    = 3'd3,
    CMD_INIT    = 3'd4,
    CMD_STIM    = 3'd5,
    CMD_STEP    = 3'd6,
    CMD_RESTORE = 3'd7
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP = 2'd0,
    CFG_ACTIVE    = 2'd1,
    CFG_TRACE     = 2'd2,
    CFG_SPARE     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic load_ring;
    logic shift;
    logic issue;
    logic gain_term;
    logic post_x;
    logic post_y;
    logic post_m;
    logic div_init;
    logic div_step;
    logic commit;
    logic restore;
    logic wr_w;
    logic wr_bias;
    logic wr_tau;
    logic wr_gain;
    logic wr_init;
    logic wr_stim;
  } cell_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7FFFFFFF;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sigmoid(input logic signed [31:0] x);
    logic [32:0] xe;
    logic [32:0] a;
    logic [32:0] y;
    logic [32:0] r;
    xe = {x[31], x};
    a  = x[31] ? (~xe + 33'd1) : xe;
    if (a >= SIG_SAT) y = ONE_Q;
    else if (a >= SIG_MID) y = (a >> 5) + SIG_OFF_HI;
    else if (a >= ONE_Q) y = (a >> 3) + SIG_OFF_MID;
    else y = (a >> 2) + SIG_OFF_LO;
    r = x[31] ? (ONE_Q - y) : y;
    return r[31:0];
  endfunction

endpackage
`default_nettype wire

@@ design/cen_in_if.sv @@
`default_nettype none
interface cen_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [3:0]  row_index;
  logic [3:0]  column_index;
  logic signed [31:0] value;
  modport source(output valid, command, row_index, column_index, value, input ready);
  modport sink(input valid, command, row_index, column_index, value, output ready);
endinterface
`default_nettype wire

@@ design/cen_out_if.sv @@
`default_nettype none
interface cen_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  neuron_index;
  logic signed [31:0] neuron_value;
  logic        last;
  modport source(output valid, neuron_index, neuron_value, last, input ready);
  modport sink(input valid, neuron_index, neuron_value, last, output ready);
endinterface
`default_nettype wire

@@ design/cen_cell.sv @@
`default_nettype none
module cen_cell #(
  parameter int unsigned MaxNeurons = cen_pkg::MAX_NEURONS_DEF,
  parameter int unsigned Idx = 0,
  localparam int unsigned IW = $clog2(MaxNeurons),
  localparam int unsigned NW = $clog2(MaxNeurons + 1)
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire cen_pkg::cell_ctl_t ctl_i,
  input  wire [IW-1:0]           row_i,
  input  wire                    row_ok_i,
  input  wire [IW-1:0]           col_i,
  input  wire                    col_ok_i,
  input  wire signed [31:0]      data_i,
  input  wire [16:0]             dt_i,
  input  wire [NW-1:0]           n_i,
  input  wire signed [31:0]      ring_p_i,
  input  wire [IW-1:0]           ring_tag_i,
  output logic signed [31:0]     ring_p_o,
  output logic [IW-1:0]          ring_tag_o
);
  import cen_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(Idx);
  localparam logic [NW-1:0] MY_N   = NW'(Idx);

  logic row_hit, col_hit, active;
  assign row_hit = row_ok_i && (row_i == MY_IDX);
  assign col_hit = row_ok_i && col_ok_i && (col_i == MY_IDX);
  assign active  = MY_N < n_i;

  logic signed [31:0] state_q, init_q, stim_q, bias_q, tau_q, gain_q;
  logic signed [31:0] p_q;
  logic [IW-1:0]      tag_q;

  // column of the weight matrix that feeds this neuron
  logic signed [31:0] wmem [MaxNeurons];
  logic signed [31:0] w_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_w && col_hit) wmem[row_i] <= data_i;
    w_q <= wmem[tag_q];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_bias && row_hit) bias_q <= data_i;
    if (ctl_i.wr_tau && row_hit)  tau_q  <= data_i;
    if (ctl_i.wr_gain && row_hit) gain_q <= data_i;
  end

  // divider and update datapath
  logic signed [63:0]           acc_q;
  logic signed [31:0]           x_q, y_q;
  logic signed [MPROD_W-1:0]    mprod_q;
  logic [DIV_W-1:0]             num_q;
  logic [31:0]                  rem_q;
  logic                         neg_q, tpos_q;
  logic signed [63:0]           delta, next_sum;

  assign delta    = neg_q ? -$signed({{(64-DIV_W){1'b0}}, num_q})
                          : $signed({{(64-DIV_W){1'b0}}, num_q});
  assign next_sum = {{32{state_q[31]}}, state_q} + delta;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      init_q  <= '0;
      stim_q  <= '0;
    end else begin
      if (ctl_i.wr_init && row_hit) init_q <= data_i;
      if (ctl_i.wr_stim && row_hit) stim_q <= data_i;
      if (ctl_i.restore) state_q <= init_q;
      else if (ctl_i.commit && active && tpos_q) state_q <= sat32(next_sum);
    end
  end

  // state ring
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_ring) begin
      p_q   <= state_q;
      tag_q <= MY_IDX;
    end else if (ctl_i.shift) begin
      p_q   <= ring_p_i;
      tag_q <= ring_tag_i;
    end
  end
  assign ring_p_o   = p_q;
  assign ring_tag_o = tag_q;

  // multiply-accumulate pipeline
  logic               v1_q, v2_q, g1_q;
  logic signed [31:0] p1_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] op_a, op_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.issue && (ctl_i.gain_term || (NW'(tag_q) < n_i));
      v2_q <= v1_q;
    end
  end

  assign op_a = g1_q ? gain_q : p1_q;
  assign op_b = g1_q ? stim_q : w_q;

  logic signed [MPROD_W-1:0] diff_dt;
  logic signed [33:0]        diff;
  logic [MPROD_W-1:0]        mag;
  logic [32:0]               trial, tdiv;

  assign diff    = {{2{y_q[31]}}, y_q} - {{2{state_q[31]}}, state_q};
  // product formed at the full width of the result
  assign diff_dt = diff * $signed({1'b0, dt_i});
  assign mag     = mprod_q[MPROD_W-1] ? MPROD_W'(-mprod_q) : mprod_q;
  assign trial   = {rem_q, num_q[DIV_W-1]};
  assign tdiv    = {1'b0, tau_q};

  always_ff @(posedge clk_i) begin
    p1_q   <= p_q;
    g1_q   <= ctl_i.gain_term;
    prod_q <= op_a * op_b;
    if (ctl_i.load_ring) acc_q <= {{32{bias_q[31]}}, bias_q};
    else if (v2_q) acc_q <= acc_q + (prod_q >>> 16);
    if (ctl_i.post_x) x_q <= sat32(acc_q);
    if (ctl_i.post_y) y_q <= sigmoid(x_q);
    if (ctl_i.post_m) mprod_q <= diff_dt;
    if (ctl_i.div_init) begin
      neg_q  <= mprod_q[MPROD_W-1];
      num_q  <= mag[DIV_W-1:0];
      rem_q  <= '0;
      tpos_q <= tau_q > 0;
    end else if (ctl_i.div_step) begin
      if (trial >= tdiv) begin
        rem_q <= 32'(trial - tdiv);
        num_q <= {num_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[31:0];
        num_q <= {num_q[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

@@ design/ctrnn_euler_step_core.sv @@
// CTRNN forward-Euler core. Load transactions are weights, bias, tau, gain,
// initial state, stimulus and restore. A step transaction runs a ring of
// MaxNeurons cells, one per neuron: the held states circulate round the ring
// while every cell multiply-accumulates its own weight column, one product per
// cycle, then each cell forms sigmoid and dt product and runs its own
// bit-serial divider by tau. The ring pass (MaxNeurons + 1 products) and the
// 50-bit divider make up most of a step; results are then read out round the
// ring, one per active neuron with trace on, else only the last one.
// Input is not taken while a step is in flight; the last result may still wait
// in the output register when the next transaction is taken.
`default_nettype none
module ctrnn_euler_step_core #(
  parameter int unsigned MaxNeurons = cen_pkg::MAX_NEURONS_DEF
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  cen_in_if.sink           in_ch,
  cen_out_if.source        out_ch,
  input  wire              cfg_we_i,
  input  wire [cen_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [cen_pkg::DT_W-1:0]      cfg_data_i
);
  import cen_pkg::*;

  localparam int unsigned IW = $clog2(MaxNeurons);
  localparam int unsigned NW = $clog2(MaxNeurons + 1);
  localparam int unsigned CW = $clog2(MaxNeurons + DIV_W + 8);
  localparam logic [CW-1:0] MAC_LAST  = CW'(MaxNeurons);  // gain product
  localparam logic [CW-1:0] DRAIN_LAST = CW'(1);
  localparam logic [CW-1:0] DIV_FIRST = CW'(4);
  localparam logic [CW-1:0] COMMIT_AT = CW'(4 + DIV_W);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SNAP  = 7'b0000010,
    ST_MAC   = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_POST  = 7'b0010000,
    ST_OUTLD = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  // configuration registers
  logic [DT_W-1:0]  dt_q;
  logic [ACT_W-1:0] act_q;
  logic             trace_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q    <= DT_RESET;
      act_q   <= ACT_RESET;
      trace_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIME_STEP: dt_q    <= cfg_data_i;
        CFG_ACTIVE:    act_q   <= cfg_data_i[ACT_W-1:0];
        CFG_TRACE:     trace_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // neuron count clamped into one .. MaxNeurons
  logic [NW-1:0] n_eff, n_last;
  always_comb begin
    if (act_q == '0) n_eff = NW'(1);
    else if (int'(act_q) > MaxNeurons) n_eff = NW'(MaxNeurons);
    else n_eff = NW'(act_q);
  end
  assign n_last = n_eff - NW'(1);

  state_e st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] k_q, k_d;

  // ring wiring
  logic signed [31:0] ring_p [MaxNeurons];
  logic [IW-1:0]      ring_tag [MaxNeurons];

  // output register
  logic               out_v_q;
  logic [3:0]         out_idx_q;
  logic signed [31:0] out_val_q;
  logic               out_last_q;

  logic adv, k_end, emit_item;
  assign adv       = !out_v_q || out_ch.ready;
  assign k_end     = NW'(k_q) == n_last;
  assign emit_item = trace_q || k_end;

  logic in_take;
  assign in_ch.ready = st_q == ST_IDLE;
  assign in_take     = in_ch.valid && in_ch.ready;

  // load decode, tau floored at 3*dt as held now
  logic row_ok, col_ok;
  logic [18:0] tau_floor;
  logic signed [31:0] wr_data;
  assign row_ok    = int'(in_ch.row_index) < MaxNeurons;
  assign col_ok    = int'(in_ch.column_index) < MaxNeurons;
  assign tau_floor = 19'(dt_q) * 19'd3;
  always_comb begin
    wr_data = in_ch.value;
    if (in_ch.command == CMD_TAU && in_ch.value < $signed({13'b0, tau_floor}))
      wr_data = $signed({13'b0, tau_floor});
  end

  cell_ctl_t ctl;

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    k_d   = k_q;
    ctl   = '0;
    case (st_q)
      ST_IDLE: begin
        if (in_take) begin
          case (in_ch.command)
            CMD_WEIGHT:  ctl.wr_w    = 1'b1;
            CMD_BIAS:    ctl.wr_bias = 1'b1;
            CMD_TAU:     ctl.wr_tau  = 1'b1;
            CMD_GAIN:    ctl.wr_gain = 1'b1;
            CMD_INIT:    ctl.wr_init = 1'b1;
            CMD_STIM:    ctl.wr_stim = 1'b1;
            CMD_RESTORE: ctl.restore = 1'b1;
            CMD_STEP:    st_d = ST_SNAP;
            default: ;
          endcase
        end
      end
      ST_SNAP: begin
        ctl.load_ring = 1'b1;
        cnt_d = '0;
        st_d  = ST_MAC;
      end
      ST_MAC: begin
        ctl.issue     = 1'b1;
        ctl.shift     = 1'b1;
        ctl.gain_term = cnt_q == MAC_LAST;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == MAC_LAST) begin
          cnt_d = '0;
          st_d  = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == DRAIN_LAST) begin
          cnt_d = '0;
          st_d  = ST_POST;
        end
      end
      ST_POST: begin
        ctl.post_x   = cnt_q == CW'(0);
        ctl.post_y   = cnt_q == CW'(1);
        ctl.post_m   = cnt_q == CW'(2);
        ctl.div_init = cnt_q == CW'(3);
        ctl.div_step = (cnt_q >= DIV_FIRST) && (cnt_q < COMMIT_AT);
        ctl.commit   = cnt_q == COMMIT_AT;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == COMMIT_AT) st_d = ST_OUTLD;
      end
      ST_OUTLD: begin
        // updated states back into the ring for read-out
        ctl.load_ring = 1'b1;
        k_d  = '0;
        st_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (adv) begin
          ctl.shift = 1'b1;
          k_d = k_q + IW'(1);
          if (k_end) st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
      k_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      k_q   <= k_d;
      if (st_q == ST_EMIT && adv && emit_item) out_v_q <= 1'b1;
      else if (out_ch.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_EMIT && adv && emit_item) begin
      out_idx_q  <= 4'(ring_tag[0]);
      out_val_q  <= ring_p[0];
      out_last_q <= k_end;
    end
  end

  assign out_ch.valid        = out_v_q;
  assign out_ch.neuron_index = out_idx_q;
  assign out_ch.neuron_value = out_val_q;
  assign out_ch.last         = out_last_q;

  // ring of neuron cells, each fed by its upper neighbour
  for (genvar j = 0; j < MaxNeurons; j++) begin : g_cell
    cen_cell #(
      .MaxNeurons(MaxNeurons),
      .Idx       (j)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .row_i     (IW'(in_ch.row_index)),
      .row_ok_i  (row_ok),
      .col_i     (IW'(in_ch.column_index)),
      .col_ok_i  (col_ok),
      .data_i    (wr_data),
      .dt_i      (dt_q),
      .n_i       (n_eff),
      .ring_p_i  (ring_p[(j + 1) % MaxNeurons]),
      .ring_tag_i(ring_tag[(j + 1) % MaxNeurons]),
      .ring_p_o  (ring_p[j]),
      .ring_tag_o(ring_tag[j])
    );
  end

  // sequencer checks
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(st_q))
    else $error("sequencer state not one-hot");
  a_snap_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_SNAP |=> (st_q == ST_MAC && cnt_q == '0))
    else $error("ring pass did not start after snapshot");
  a_emit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EMIT && adv && k_end) |=> (st_q == ST_IDLE && out_v_q && out_ch.last))
    else $error("final result of a step not flagged last");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && in_ch.command == CMD_STEP) |=> !in_ch.ready)
    else $error("input taken while a step is in flight");

endmodule
`default_nettype wire
